// ===== rtl/imdec_pkg.sv =====
`default_nettype none

package imdec_pkg;

    // Default capture timer width; the low TIMER_BITS bits of period and pulse count
    localparam int IMDEC_TIMER_BITS = 32;

    // Quotient width of the shared divider (frequency is the widest result)
    localparam int QW = 27;
    // Width of the divider step count
    localparam int NB_W = 5;

    // Quotient bits per division
    localparam logic [NB_W-1:0] FREQ_BITS = NB_W'(27);
    localparam logic [NB_W-1:0] DUTY_BITS = NB_W'(14);
    localparam logic [NB_W-1:0] RES_BITS  = NB_W'(21);

    // Result status codes
    localparam logic [2:0] CODE_NORMAL       = 3'd0;
    localparam logic [2:0] CODE_UNDERVOLTAGE = 3'd1;
    localparam logic [2:0] CODE_SELF_TEST    = 3'd2;
    localparam logic [2:0] CODE_DEVICE_ERROR = 3'd3;
    localparam logic [2:0] CODE_GROUND_FAULT = 3'd4;
    localparam logic [2:0] CODE_UNKNOWN      = 3'd5;
    localparam logic [2:0] CODE_DISCONNECTED = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLOCK_HZ      = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;

    localparam logic [19:0] CLOCK_HZ_RESET  = 20'd500000;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd250;
    localparam logic [19:0] OPEN_KOHM       = 20'd999999;
    localparam logic [13:0] DUTY_FULL       = 14'd10000;
    localparam logic [QW-1:0] DUTY_KNEE     = QW'(510);
    localparam logic [QW-1:0] RES_OFFSET    = QW'(1200);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FREQ = 5'b00010,
        S_DUTY = 5'b00100,
        S_RES  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic          done;
        logic          rem_nz;
        logic [QW-1:0] quot;
    } div_stat_t;

    // Frequency band test on q = floor(100*clk/period) and a nonzero-remainder flag:
    // clk > lo*period and clk < hi*period, with lo100/hi100 the limits times 100.
    function automatic logic in_band(input logic [QW-1:0] q, input logic rnz,
                                     input logic [QW-1:0] lo100,
                                     input logic [QW-1:0] hi100);
        return ((q > lo100) || ((q == lo100) && rnz)) && (q < hi100);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/isolation_monitor_pwm_decoder.sv =====
`default_nettype none

// Insulation monitor PWM status decoder. Each input transfer is either a PWM
// capture (command 0: period and high time in capture timer ticks) or a 1 ms
// timebase tick (command 1). A capture produces one result: frequency in
// centihertz, duty in centipercent (saturated at 10000), the status band
// (10/20/30/40/50 Hz, +-1 Hz exclusive, else unknown) and the isolation
// resistance in kilohm (derived from duty in the 10 Hz band, 0 in the other
// known bands, last value kept when unknown). A tick produces a result only
// when timeout_ticks ticks pass without a capture: state disconnected with all
// values 0. A capture runs up to three passes through one shared restoring
// divider that retires one quotient bit per cycle: frequency (27 bits), duty
// (14 bits, skipped when the pulse is not shorter than the period) and
// resistance (21 bits, 10 Hz band only); a zero period skips the divider.
// The input is not ready while an item is in work; a finished result waits
// in the output register while the next item is accepted. Configuration
// writes are taken in any cycle.
module isolation_monitor_pwm_decoder
    import imdec_pkg::*;
#(
    parameter int TIMER_BITS = IMDEC_TIMER_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [31:0] s_capture_period,
    input  wire logic [31:0] s_capture_pulse,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_state_code,
    output logic [19:0]      m_isolation_kohm,
    output logic [26:0]      m_frequency_centihz,
    output logic [13:0]      m_duty_centipercent
);

    localparam int DW   = TIMER_BITS + 5;
    localparam int NUMW = TIMER_BITS + 15;

    // Configuration registers
    logic [19:0] clock_hz_reg;
    logic [15:0] timeout_reg;

    // Sequencer and working registers
    state_t                state_reg, state_next;
    logic                  start_reg, start_next;
    logic [TIMER_BITS-1:0] period_reg, period_next;
    logic [TIMER_BITS-1:0] pulse_reg, pulse_next;
    logic [15:0]           ticks_reg, ticks_next;
    logic [19:0]           last_res_reg, last_res_next;
    logic [2:0]            code_reg, code_next;
    logic [26:0]           freq_reg, freq_next;
    logic [13:0]           duty_reg, duty_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            m_code_reg, m_code_next;
    logic [19:0]           m_res_reg, m_res_next;
    logic [26:0]           m_freq_reg, m_freq_next;
    logic [13:0]           m_duty_reg, m_duty_next;

    logic                  in_xfer;
    logic                  out_free;
    logic [15:0]           tick_inc;
    logic [2:0]            band_code;
    logic [QW-1:0]         res_sub;

    // Divider operands
    logic [NUMW-1:0]       num_freq, num_duty, num_res;
    logic [DW-1:0]         div_hi, div_den;
    logic [NUMW-1:0]       div_lo;
    logic [NB_W-1:0]       div_bits;
    div_stat_t             div_stat;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign tick_inc  = ticks_reg + 16'd1;

    assign m_valid             = m_valid_reg;
    assign m_state_code        = m_code_reg;
    assign m_isolation_kohm    = m_res_reg;
    assign m_frequency_centihz = m_freq_reg;
    assign m_duty_centipercent = m_duty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CLOCK_HZ:      clock_hz_reg <= cfg_data;
                CFG_TIMEOUT_TICKS: timeout_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Select the operation the divider runs in the current state.
    // Each numerator is split into the part already below the divisor and
    // the low bits that get shifted in, one per quotient bit.
    assign num_freq = NUMW'(clock_hz_reg) * NUMW'(100);
    assign num_duty = NUMW'(pulse_reg) * NUMW'(10000);
    assign num_res  = NUMW'(period_reg) * NUMW'(21600);

    always_comb begin
        div_hi   = DW'(num_freq >> 27);
        div_lo   = num_freq << (NUMW - 27);
        div_bits = FREQ_BITS;
        div_den  = DW'(period_reg);
        case (state_reg)
            S_DUTY: begin
                div_hi   = DW'(num_duty >> 14);
                div_lo   = num_duty << (NUMW - 14);
                div_bits = DUTY_BITS;
                div_den  = DW'(period_reg);
            end
            S_RES: begin
                div_hi   = DW'(num_res >> 21);
                div_lo   = num_res << (NUMW - 21);
                div_bits = RES_BITS;
                div_den  = DW'(pulse_reg) * DW'(20) - DW'(period_reg);
            end
            default: ;
        endcase
    end

    imdec_div #(
        .TIMER_BITS(TIMER_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num_hi  (div_hi),
        .num_lo  (div_lo),
        .nbits   (div_bits),
        .den     (div_den),
        .stat    (div_stat)
    );

    // Classify the frequency quotient into a status band
    always_comb begin
        if (in_band(div_stat.quot, div_stat.rem_nz, QW'(900), QW'(1100))) begin
            band_code = CODE_NORMAL;
        end else if (in_band(div_stat.quot, div_stat.rem_nz, QW'(1900), QW'(2100))) begin
            band_code = CODE_UNDERVOLTAGE;
        end else if (in_band(div_stat.quot, div_stat.rem_nz, QW'(2900), QW'(3100))) begin
            band_code = CODE_SELF_TEST;
        end else if (in_band(div_stat.quot, div_stat.rem_nz, QW'(3900), QW'(4100))) begin
            band_code = CODE_DEVICE_ERROR;
        end else if (in_band(div_stat.quot, div_stat.rem_nz, QW'(4900), QW'(5100))) begin
            band_code = CODE_GROUND_FAULT;
        end else begin
            band_code = CODE_UNKNOWN;
        end
    end

    assign res_sub = div_stat.quot - RES_OFFSET;

    always_comb begin
        state_next    = state_reg;
        start_next    = 1'b0;
        period_next   = period_reg;
        pulse_next    = pulse_reg;
        ticks_next    = ticks_reg;
        last_res_next = last_res_reg;
        code_next     = code_reg;
        freq_next     = freq_reg;
        duty_next     = duty_reg;

        m_valid_next  = m_valid_reg;
        m_code_next   = m_code_reg;
        m_res_next    = m_res_reg;
        m_freq_next   = m_freq_reg;
        m_duty_next   = m_duty_reg;

        // Drop the result once the downstream side takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    if (s_command) begin
                        // Timebase tick: advance the idle count, time out at the limit
                        if (tick_inc >= timeout_reg) begin
                            ticks_next    = '0;
                            last_res_next = '0;
                            code_next     = CODE_DISCONNECTED;
                            freq_next     = '0;
                            duty_next     = '0;
                            state_next    = S_DONE;
                        end else begin
                            ticks_next = tick_inc;
                        end
                    end else begin
                        ticks_next  = '0;
                        period_next = s_capture_period[TIMER_BITS-1:0];
                        pulse_next  = s_capture_pulse[TIMER_BITS-1:0];
                        freq_next   = '0;
                        duty_next   = '0;
                        if (s_capture_period[TIMER_BITS-1:0] == '0) begin
                            // Zero period: no measurement, keep the last resistance
                            code_next  = CODE_UNKNOWN;
                            state_next = S_DONE;
                        end else begin
                            start_next = 1'b1;
                            state_next = S_FREQ;
                        end
                    end
                end
            end

            S_FREQ: begin
                if (div_stat.done) begin
                    freq_next = div_stat.quot;
                    code_next = band_code;
                    if (band_code != CODE_NORMAL && band_code != CODE_UNKNOWN) begin
                        last_res_next = '0;
                    end
                    if (pulse_reg >= period_reg) begin
                        // Duty saturates; the resistance condition holds
                        duty_next = DUTY_FULL;
                        if (band_code == CODE_NORMAL) begin
                            start_next = 1'b1;
                            state_next = S_RES;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else begin
                        start_next = 1'b1;
                        state_next = S_DUTY;
                    end
                end
            end

            S_DUTY: begin
                if (div_stat.done) begin
                    duty_next = div_stat.quot[13:0];
                    if (code_reg == CODE_NORMAL) begin
                        // 1000*pulse > 51*period, read off the duty quotient
                        if ((div_stat.quot > DUTY_KNEE) ||
                            ((div_stat.quot == DUTY_KNEE) && div_stat.rem_nz)) begin
                            start_next = 1'b1;
                            state_next = S_RES;
                        end else begin
                            last_res_next = OPEN_KOHM;
                            state_next    = S_DONE;
                        end
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end

            S_RES: begin
                if (div_stat.done) begin
                    // Remove the offset, clamp at zero and at the open value
                    if (div_stat.quot <= RES_OFFSET) begin
                        last_res_next = '0;
                    end else if (res_sub > QW'(OPEN_KOHM)) begin
                        last_res_next = OPEN_KOHM;
                    end else begin
                        last_res_next = res_sub[19:0];
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free, then load it
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = code_reg;
                    m_res_next   = last_res_reg;
                    m_freq_next  = freq_reg;
                    m_duty_next  = duty_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            ticks_reg    <= '0;
            last_res_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            start_reg    <= start_next;
            ticks_reg    <= ticks_next;
            last_res_reg <= last_res_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        pulse_reg  <= pulse_next;
        code_reg   <= code_next;
        freq_reg   <= freq_next;
        duty_reg   <= duty_next;
        m_code_reg <= m_code_next;
        m_res_reg  <= m_res_next;
        m_freq_reg <= m_freq_next;
        m_duty_reg <= m_duty_next;
    end

endmodule

`default_nettype wire

// ===== rtl/imdec_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module imdec_div
    import imdec_pkg::*;
#(
    parameter int TIMER_BITS = IMDEC_TIMER_BITS
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [TIMER_BITS+4:0]      num_hi,
    input  wire logic [TIMER_BITS+14:0]     num_lo,
    input  wire logic [NB_W-1:0]            nbits,
    input  wire logic [TIMER_BITS+4:0]      den,
    output div_stat_t                       stat
);

    localparam int DW   = TIMER_BITS + 5;
    localparam int NUMW = TIMER_BITS + 15;

    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg;
    logic [NUMW-1:0] nsh_reg;
    logic [QW-1:0]   quot_reg;
    logic [NB_W-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_reg, nsh_reg[NUMW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - NB_W'(1);
                if (cnt_reg == NB_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num_hi;
            nsh_reg  <= num_lo;
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            nsh_reg  <= {nsh_reg[NUMW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], ge};
        end
    end

    assign stat.done   = done_reg;
    assign stat.rem_nz = |rem_reg;
    assign stat.quot   = quot_reg;

endmodule

`default_nettype wire
